// ===== rtl/srs_pkg.sv =====
// Shared types and constants for the step rate steering block.
package srs_pkg;

	localparam int REG_IDX_W = 3;
	localparam int FRAC_BITS = 8;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_STEP_ORIGIN = 3'd0,
		REG_LP_CLOCK_HZ = 3'd1,
		REG_PARK_RATE   = 3'd2,
		REG_MIN_CYCLES  = 3'd3,
		REG_TRACK_GAIN  = 3'd4,
		REG_DEADBAND    = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL_FF,
		ST_DIV_FF,
		ST_SPEED,
		ST_CHECK,
		ST_DIV_PER,
		ST_FINISH,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic mul_ff;
		logic div_start;
		logic div_sel_per;
		logic speed;
		logic check;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic do_period;
		logic estop;
	} sts_t;

endpackage

// ===== rtl/srs_div.sv =====
// Restoring divider, one quotient bit per cycle.
module srs_div import srs_pkg::*; #(
	parameter int NW = 64,
	parameter int DW = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo,
	output logic          done
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW+1:0] diff;

	assign trial = {rem_q[DW-1:0], quo_q[NW-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[DW+1]) begin
				rem_q <= diff[DW:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign quo  = quo_q;
	assign done = done_q;
endmodule

// ===== rtl/srs_datapath.sv =====
// Datapath: registers, state, feedforward, speed and period arithmetic.
module srs_datapath import srs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic                 cfg_valid,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic [31:0]          plan_position,
	input  logic [31:0]          step_count,
	input  logic [19:0]          elapsed_us,
	input  logic                 estop,
	input  logic                 reseed,
	output logic [31:0]          step_period_q8,
	output logic                 move_dir,
	output logic                 clamp_fault,
	output logic [31:0]          fault_total
);
	localparam int MW = 32 + FRAC_BITS + 2;
	localparam int NW = 27 + 2 * FRAC_BITS + 1;
	localparam int DNW = (NW > 53) ? NW : 53;
	localparam logic [45:0] CAP = 46'(1) << 44;

	logic signed [31:0] origin_q;
	logic [26:0]        hz_q;
	logic [15:0]        park_q;
	logic [9:0]         minc_q;
	logic [7:0]         gain_q;
	logic [15:0]        dband_q;

	logic signed [31:0] prev_q;
	logic               dir_q;
	logic [31:0]        fcnt_q;

	logic signed [31:0] plan_q;
	logic [19:0]        el_q;
	logic               estop_q;
	logic signed [MW-1:0] meas_q;
	logic signed [33:0] diff_q;
	logic [32:0]        dmag_q;
	logic [52:0]        ffnum_q;
	logic signed [MW:0] err_q;
	logic signed [MW+9:0] corr_q;
	logic               use_corr_q;
	logic signed [55:0] v_q;
	logic [44:0]        mag_q;
	logic               go_q;
	logic               floor_q;
	logic [31:0]        period_q;
	logic               clamp_q;

	logic [DNW-1:0] dnum;
	logic [44:0]    dden;
	logic [DNW-1:0] dquo;
	logic           ddone;

	logic [31:0]          rawd;
	logic signed [MW-1:0] meas_c;
	logic signed [31:0]   base_c;
	logic signed [MW-1:0] sat_c;
	logic signed [55:0]   ff_c;
	logic signed [55:0]   v_c;
	logic [55:0]          vabs_c;
	logic [9:0]           mc_c;
	logic [NW-1:0]        e2_c;
	logic [DNW-1:0]       per_c;

	assign rawd   = step_count - origin_q;
	assign meas_c = MW'($signed(rawd)) <<< FRAC_BITS;
	assign sat_c  = (meas_c > MW'(32'sh7FFFFFFF)) ? MW'(32'sh7FFFFFFF) :
	                (meas_c < -MW'(64'sh80000000)) ? -MW'(64'sh80000000) : meas_c;
	assign base_c = reseed ? 32'(sat_c) : prev_q;

	assign ff_c   = diff_q[33] ? -$signed({3'b000, dquo[52:0]}) : $signed({3'b000, dquo[52:0]});
	assign v_c    = ff_c + (use_corr_q ? 56'(corr_q) : 56'sd0);
	assign vabs_c = v_q[55] ? 56'(-v_q) : 56'(v_q);
	assign mc_c   = (minc_q == '0) ? 10'd1 : minc_q;
	assign e2_c   = NW'(hz_q) << (2 * FRAC_BITS);
	assign per_c  = dquo;

	always_comb begin
		if (cmd.div_sel_per) begin
			dnum = DNW'(e2_c) + DNW'(mag_q >> 1);
			dden = mag_q;
		end else begin
			dnum = DNW'(ffnum_q) + DNW'(el_q >> 1);
			dden = 45'(el_q);
		end
	end

	srs_div #(.NW(DNW), .DW(45)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(dnum), .den(dden), .quo(dquo), .done(ddone)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
			hz_q     <= 27'd40000000;
			park_q   <= 16'd614;
			minc_q   <= 10'd40;
			gain_q   <= 8'd50;
			dband_q  <= 16'd256;
			prev_q   <= '0;
			dir_q    <= 1'b1;
			fcnt_q   <= '0;
			period_q <= '0;
			clamp_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_STEP_ORIGIN: origin_q <= cfg_data;
					REG_LP_CLOCK_HZ: hz_q     <= cfg_data[26:0];
					REG_PARK_RATE:   park_q   <= cfg_data[15:0];
					REG_MIN_CYCLES:  minc_q   <= cfg_data[9:0];
					REG_TRACK_GAIN:  gain_q   <= cfg_data[7:0];
					REG_DEADBAND:    dband_q  <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				period_q <= '0;
				clamp_q  <= 1'b0;
				if (!estop) prev_q <= plan_position;
			end
			if (cmd.finish && go_q) begin
				dir_q <= ~v_q[55];
				if (floor_q) begin
					period_q <= 32'(mc_c) << FRAC_BITS;
					clamp_q  <= 1'b1;
					fcnt_q   <= fcnt_q + 1'b1;
				end else begin
					period_q <= (per_c > DNW'(32'hFFFFFFFF)) ? 32'hFFFFFFFF : 32'(per_c);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			plan_q  <= plan_position;
			el_q    <= (elapsed_us == '0) ? 20'd1 : elapsed_us;
			estop_q <= estop;
			meas_q  <= meas_c;
			diff_q  <= 34'($signed(plan_position)) - 34'(base_c);
		end
		if (cmd.prep) begin
			dmag_q     <= diff_q[33] ? 33'(-diff_q) : 33'(diff_q);
			err_q      <= (MW + 1)'(plan_q) - (MW + 1)'(meas_q);
			use_corr_q <= 1'b0;
		end
		if (cmd.mul_ff) begin
			ffnum_q    <= 53'(dmag_q) * 53'd1000000;
			corr_q     <= (MW + 10)'(err_q) * $signed({1'b0, gain_q});
			use_corr_q <= (err_q[MW] ? -err_q : err_q) > (MW + 1)'(dband_q);
		end
		if (cmd.speed) v_q <= v_c;
		if (cmd.check) begin
			mag_q <= (vabs_c > 56'(CAP)) ? 45'(CAP) : 45'(vabs_c);
			go_q  <= 1'b0;
		end
		if (cmd.div_start && cmd.div_sel_per) begin
			go_q    <= (mag_q != '0) && (mag_q >= 45'(park_q));
			floor_q <= (64'(hz_q) << FRAC_BITS) < 64'(mc_c) * 64'(mag_q);
		end
	end

	assign sts.div_done  = ddone;
	assign sts.do_period = 1'b1;
	assign sts.estop     = estop_q;

	assign step_period_q8 = period_q;
	assign move_dir       = dir_q;
	assign clamp_fault    = clamp_q;
	assign fault_total    = fcnt_q;
endmodule

// ===== rtl/srs_ctrl.sv =====
// Controller state machine sequencing one tick through the datapath.
module srs_ctrl import srs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd,
	input  sts_t sts
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				if (sts.estop) state_d = ST_OUT;
				else begin
					cmd.prep = 1'b1;
					state_d  = ST_MUL_FF;
				end
			end
			ST_MUL_FF: begin
				cmd.mul_ff    = 1'b1;
				state_d       = ST_DIV_FF;
			end
			ST_DIV_FF: begin
				cmd.div_start = 1'b1;
				state_d       = ST_SPEED;
			end
			ST_SPEED: begin
				if (sts.div_done) begin
					cmd.speed = 1'b1;
					state_d   = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = ST_DIV_PER;
			end
			ST_DIV_PER: begin
				cmd.div_start   = sts.do_period;
				cmd.div_sel_per = 1'b1;
				state_d         = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.div_done) begin
					cmd.finish = 1'b1;
					state_d    = ST_OUT;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ===== rtl/step_rate_steering.sv =====
// Top level of the step rate steering block.
// One tick makes two passes through a shared 53-bit restoring divider, one
// quotient bit per cycle: first the feedforward velocity, then the period.
// An estop tick goes straight to the output and skips both divider passes.
// Results are held in output registers until transferred; the next tick
// is taken after the result transfer.
module step_rate_steering import srs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [31:0]          plan_position,
	input  logic [31:0]          step_count,
	input  logic [19:0]          elapsed_us,
	input  logic                 estop,
	input  logic                 reseed,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          step_period_q8,
	output logic                 move_dir,
	output logic                 clamp_fault,
	output logic [31:0]          fault_total,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);
	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	srs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
	);

	srs_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.plan_position(plan_position), .step_count(step_count),
		.elapsed_us(elapsed_us), .estop(estop), .reseed(reseed),
		.step_period_q8(step_period_q8), .move_dir(move_dir),
		.clamp_fault(clamp_fault), .fault_total(fault_total)
	);

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(clamp_fault) |-> fault_total == $past(fault_total) + 32'd1)
		else $error("fault count not advanced");
	a_park: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && step_period_q8 == '0 |-> !clamp_fault)
		else $error("parked with clamp");
endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for step_rate_steering: directed table, then random ticks.
module tb_top import srs_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] plan_position;
	logic [31:0] step_count;
	logic [19:0] elapsed_us;
	logic        estop;
	logic        reseed;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] step_period_q8;
	logic        move_dir;
	logic        clamp_fault;
	logic [31:0] fault_total;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	step_rate_steering u_top (.*);

	typedef struct packed {
		logic [31:0] period;
		logic        dir;
		logic        clamp;
		logic [31:0] faults;
	} tick_result_t;

	typedef struct {
		logic [31:0] plan;
		logic [31:0] count;
		logic [19:0] elapsed;
		logic        stop;
		logic        seed;
		bit          typed;
		tick_result_t want;
	} tick_row_t;

	// predictor copy of registers and state
	longint m_origin, m_clock, m_park, m_minc, m_gain, m_dead;
	longint m_prev;
	bit     m_dir;
	logic [31:0] m_faults;

	tick_result_t expected_q[$];
	int fail_cnt;
	int sender_idle, receiver_idle;

	function automatic longint mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic tick_result_t predict_tick(logic [31:0] plan_in, logic [31:0] count_in,
			logic [19:0] el_in, logic stop_in, logic seed_in);
		tick_result_t r;
		longint plan, meas, diff, ff, err, v, mv, el, mc;
		longint unsigned q, um, e2, num1;
		logic [31:0] rawd;
		plan = longint'($signed(plan_in));
		r.period = '0;
		r.clamp = 1'b0;
		if (!stop_in) begin
			rawd = count_in - m_origin[31:0];
			meas = longint'($signed(rawd)) * 256;
			el = (el_in == 0) ? 1 : longint'(el_in);
			if (seed_in) begin
				m_prev = meas > 64'sd2147483647 ? 64'sd2147483647
					: (meas < -64'sd2147483648 ? -64'sd2147483648 : meas);
			end
			diff = plan - m_prev;
			m_prev = plan;
			q = (longint'(mag(diff)) * 1000000 + el / 2) / el;
			ff = diff < 0 ? -longint'(q) : longint'(q);
			err = plan - meas;
			v = ff;
			if (mag(err) > m_dead)
				v += err * m_gain;
			mv = mag(v);
			if (mv > (64'sd1 << 44))
				mv = 64'sd1 << 44;
			if (mv != 0 && mv >= m_park) begin
				um = mv;
				mc = m_minc ? m_minc : 1;
				num1 = m_clock << 8;
				if (num1 < mc * um) begin
					r.period = 32'(mc << 8);
					r.clamp = 1'b1;
					m_faults = m_faults + 1;
				end else begin
					e2 = ((m_clock << 16) + um / 2) / um;
					r.period = e2 > 64'hFFFFFFFF ? 32'hFFFFFFFF : e2[31:0];
				end
				m_dir = v >= 0;
			end
		end
		r.dir = m_dir;
		r.faults = m_faults;
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("tb_top failed");
		$finish;
	end

	// receiver side and comparison
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("unexpected transfer period=%h", step_period_q8);
				end else begin
					tick_result_t w;
					w = expected_q.pop_front();
					if (w.period !== step_period_q8 || w.dir !== move_dir ||
							w.clamp !== clamp_fault || w.faults !== fault_total) begin
						fail_cnt++;
						if (fail_cnt <= 10)
							$display("mismatch exp %h/%b/%b/%h got %h/%b/%b/%h", w.period, w.dir,
								w.clamp, w.faults, step_period_q8, move_dir, clamp_fault,
								fault_total);
					end
				end
			end
			out_ready <= ($urandom_range(99) >= receiver_idle);
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_STEP_ORIGIN: m_origin = longint'($signed(val));
			REG_LP_CLOCK_HZ: m_clock = longint'(val[26:0]);
			REG_PARK_RATE:   m_park = longint'(val[15:0]);
			REG_MIN_CYCLES:  m_minc = longint'(val[9:0]);
			REG_TRACK_GAIN:  m_gain = longint'(val[7:0]);
			REG_DEADBAND:    m_dead = longint'(val[15:0]);
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_tick(tick_row_t row);
		tick_result_t p;
		if ($urandom_range(99) < sender_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle);
		end
		in_valid      <= 1'b1;
		plan_position <= row.plan;
		step_count    <= row.count;
		elapsed_us    <= row.elapsed;
		estop         <= row.stop;
		reseed        <= row.seed;
		do @(posedge clk); while (!in_ready);
		p = predict_tick(row.plan, row.count, row.elapsed, row.stop, row.seed);
		if (row.typed && p !== row.want) begin
			fail_cnt++;
			if (fail_cnt <= 10)
				$display("predictor disagrees with table row");
		end
		expected_q.push_back(p);
	endtask

	task automatic drain;
		int guard;
		in_valid <= 1'b0;
		guard = 0;
		while (expected_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (200) @(posedge clk);
	endtask

	function automatic logic [31:0] pick32;
		case ($urandom_range(5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom_range(511);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_config;
		write_reg(REG_STEP_ORIGIN, $urandom_range(1) ? pick32() : $urandom_range(2000) - 1000);
		write_reg(REG_LP_CLOCK_HZ, $urandom_range(1) ? $urandom_range(100000000, 1)
			: $urandom_range(1) ? 1 : 100000000);
		write_reg(REG_PARK_RATE, $urandom_range(2) ? $urandom_range(2000) : $urandom_range(65535));
		write_reg(REG_MIN_CYCLES, $urandom_range(3) ? $urandom_range(1023, 1) : 1023);
		write_reg(REG_TRACK_GAIN, $urandom_range(255));
		write_reg(REG_DEADBAND, $urandom_range(2) ? $urandom_range(1024) : 65535);
	endtask

	tick_row_t rows[$];
	tick_row_t r;
	logic [31:0] pos;

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		plan_position = '0;
		step_count = '0;
		elapsed_us = 20'd1000;
		estop = 1'b0;
		reseed = 1'b0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fail_cnt = 0;
		sender_idle = 22;
		receiver_idle = 88;
		m_origin = 0; m_clock = 40000000; m_park = 614; m_minc = 40; m_gain = 50; m_dead = 256;
		m_prev = 0; m_dir = 1'b1; m_faults = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plan, count, elapsed, estop, reseed, typed, expected
		rows = '{
			'{32'd0, 32'd0, 20'd1000, 1'b0, 1'b0, 1'b1, '{32'd0, 1'b1, 1'b0, 32'd0}},
			'{32'd0, 32'd0, 20'd1000, 1'b1, 1'b0, 1'b1, '{32'd0, 1'b1, 1'b0, 32'd0}},
			'{32'h7FFFFFFF, 32'd0, 20'd1, 1'b0, 1'b0, 1'b1, '{32'd10240, 1'b1, 1'b1, 32'd1}},
			'{32'h80000000, 32'd0, 20'd1, 1'b0, 1'b0, 1'b1, '{32'd10240, 1'b0, 1'b1, 32'd2}},
			'{32'h80000000, 32'h80000000, 20'hFFFFF, 1'b0, 1'b1, 1'b0, '{default:0}},
			'{32'd25600, 32'd100, 20'd1000, 1'b0, 1'b1, 1'b0, '{default:0}},
			'{32'd51200, 32'd100, 20'd1000, 1'b0, 1'b0, 1'b0, '{default:0}},
			'{32'd51000, 32'd200, 20'd0, 1'b0, 1'b0, 1'b0, '{default:0}},
			'{32'd51000, 32'd199, 20'hFFFFF, 1'b0, 1'b0, 1'b0, '{default:0}},
			'{32'd50000, 32'd195, 20'd999, 1'b0, 1'b0, 1'b0, '{default:0}},
			'{32'd50010, 32'd195, 20'd1000, 1'b0, 1'b0, 1'b0, '{default:0}},
			'{32'h7FFFFFFF, 32'h7FFFFFFF, 20'd500, 1'b0, 1'b1, 1'b0, '{default:0}},
			'{32'h12345678, 32'h00123456, 20'd1000, 1'b1, 1'b1, 1'b0, '{default:0}},
			'{32'hFFFFFF00, 32'hFFFFFFFF, 20'd1000, 1'b0, 1'b1, 1'b0, '{default:0}},
			'{32'hFFFF0000, 32'hFFFFFF00, 20'd1000, 1'b0, 1'b0, 1'b0, '{default:0}}
		};
		foreach (rows[i])
			send_tick(rows[i]);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 4) begin
				sender_idle = 88;
				receiver_idle = 22;
			end else if (ph == 7) begin
				sender_idle = 0;
				receiver_idle = 0;
			end
			if (ph == 1) begin
				write_reg(REG_STEP_ORIGIN, 32'h80000000);
				write_reg(REG_LP_CLOCK_HZ, 32'd1);
				write_reg(REG_PARK_RATE, 32'd0);
				write_reg(REG_MIN_CYCLES, 32'd1);
				write_reg(REG_TRACK_GAIN, 32'd0);
				write_reg(REG_DEADBAND, 32'd0);
			end else if (ph == 2) begin
				write_reg(REG_STEP_ORIGIN, 32'h7FFFFFFF);
				write_reg(REG_LP_CLOCK_HZ, 32'd100000000);
				write_reg(REG_PARK_RATE, 32'd65535);
				write_reg(REG_MIN_CYCLES, 32'd1023);
				write_reg(REG_TRACK_GAIN, 32'd255);
				write_reg(REG_DEADBAND, 32'd65535);
			end else if (ph != 0) begin
				random_config();
			end
			pos = $urandom;
			for (int k = 0; k < 155; k++) begin
				if ($urandom_range(9) < 8) begin
					// smooth trajectory with a measured count tracking it
					pos = pos + ($urandom_range(1) ? $urandom_range(4000) - 2000
						: $urandom_range(200000) - 100000);
					r.plan = pos;
					r.count = 32'((longint'($signed(pos)) >>> 8) + m_origin
						+ $urandom_range(20) - 10);
					r.elapsed = $urandom_range(3) ? 20'($urandom_range(1100, 900))
						: 20'($urandom_range(1048575));
					r.stop = ($urandom_range(19) == 0);
					r.seed = ($urandom_range(14) == 0);
				end else begin
					r.plan = pick32();
					r.count = pick32();
					r.elapsed = $urandom_range(1) ? 20'($urandom) : 20'($urandom_range(3));
					r.stop = 1'($urandom_range(1));
					r.seed = 1'($urandom_range(1));
				end
				r.typed = 1'b0;
				r.want = '0;
				send_tick(r);
			end
			drain();
		end

		if (fail_cnt == 0 && expected_q.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/srs_pkg.sv
rtl/srs_div.sv
rtl/srs_datapath.sv
rtl/srs_ctrl.sv
rtl/step_rate_steering.sv
test/tb_top.sv
